// ===== src/mnpe_pkg.sv =====
// Shared types and constants for the MIDI note pairing engine.
package mnpe_pkg;

   localparam int CHANNELS = 16;
   localparam int KEYS     = 128;
   localparam int CHAN_W   = 4;
   localparam int KEY_W    = 7;
   localparam int QADDR_W  = CHAN_W + KEY_W;
   localparam int QROWS    = CHANNELS * KEYS;
   localparam int TICK_W   = 31;
   localparam int LEVEL_W  = 7;
   localparam int BEND_W   = 14;
   localparam int CODE_W   = 3;

   localparam int REQ_DATA_W = 64;
   localparam int RSP_DATA_W = 104;

   // Event actions
   localparam logic [CODE_W-1:0] ACT_NOTE_ON  = 3'd0;
   localparam logic [CODE_W-1:0] ACT_NOTE_OFF = 3'd1;
   localparam logic [CODE_W-1:0] ACT_PROGRAM  = 3'd2;
   localparam logic [CODE_W-1:0] ACT_CONTROL  = 3'd3;
   localparam logic [CODE_W-1:0] ACT_BEND     = 3'd4;

   // Record kinds
   localparam logic [CODE_W-1:0] KIND_NOTE    = 3'd0;
   localparam logic [CODE_W-1:0] KIND_CONTROL = 3'd1;
   localparam logic [CODE_W-1:0] KIND_PEDAL   = 3'd2;
   localparam logic [CODE_W-1:0] KIND_BEND    = 3'd3;
   localparam logic [CODE_W-1:0] KIND_DROP    = 3'd4;

   localparam logic [KEY_W-1:0]   SUSTAIN_CTRL   = 7'd64;
   localparam logic [LEVEL_W-1:0] PEDAL_ON_LEVEL = 7'd64;
   localparam logic [CHAN_W-1:0]  DRUM_CHANNEL   = 4'd9;

   typedef struct packed {
      logic [TICK_W-1:0]  tick;
      logic [LEVEL_W-1:0] vel;
   } pend_type;

   typedef struct packed {
      logic [CODE_W-1:0]        action;
      logic [TICK_W-1:0]        tick;
      logic [CHAN_W-1:0]        channel;
      logic [KEY_W-1:0]         number;
      logic [LEVEL_W-1:0]       level;
      logic signed [BEND_W-1:0] bend;
   } event_type;

   typedef struct packed {
      logic [CODE_W-1:0]        kind;
      logic [CHAN_W-1:0]        channel;
      logic [KEY_W-1:0]         prog;
      logic                     is_drum;
      logic [TICK_W-1:0]        start_tick;
      logic [TICK_W-1:0]        duration;
      logic [KEY_W-1:0]         number;
      logic [LEVEL_W-1:0]       level;
      logic signed [BEND_W-1:0] bend;
      logic                     last;
   } rec_type;

endpackage

// ===== src/midi_note_pairing_engine.sv =====
// Top level: pairs note-ons with note-offs, tracks program and sustain pedal per channel.
//
//  port group | direction | tdata                                   | tuser  | tlast
//  req_       | in        | tick, channel, number, level, bend      | action | -
//  rsp_       | out       | channel, program, drum, start, duration,| kind   | last
//             |           | number, level, bend                     |        |
//
// An event is taken every cycle while the output register can absorb its records; an
// event that yields two records holds the output until both have been taken.
// The accepting edge reads the queue memory; the edge on which the update stage goes on
// writes the update and loads the output register, from which the first record is on rsp_.
// After reset all 2048 rows of the queue state memory are cleared with req_tready low.
// A stalled rsp_ side holds the update stage and then the input.
module midi_note_pairing_engine #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // tick[30:0], channel[34:31], number[41:35], level[48:42], bend[62:49], zero[63]
   input  logic [mnpe_pkg::REQ_DATA_W-1:0]   req_tdata,
   // action[2:0]
   input  logic [mnpe_pkg::CODE_W-1:0]       req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // channel[3:0], program[10:4], is_drum[11], start_tick[42:12], duration[73:43],
   // number[80:74], level[87:81], bend[101:88], zero[103:102]
   output logic [mnpe_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   // kind[2:0]
   output logic [mnpe_pkg::CODE_W-1:0]       rsp_tuser,
   output logic                              rsp_tlast
);
   import mnpe_pkg::*;

   localparam int HEAD_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
   localparam int SUM_W  = CNT_W + 1;
   localparam logic [CNT_W-1:0]  DEPTH_C     = CNT_W'(QUEUE_DEPTH);
   localparam logic [SUM_W-1:0]  DEPTH_S     = SUM_W'(QUEUE_DEPTH);
   localparam logic [HEAD_W-1:0] HEAD_LAST_C = HEAD_W'(QUEUE_DEPTH - 1);

   // Input and update stage
   logic       req_fire, rsp_fire, s1_go, load_ok, clear_done;
   logic       s1_valid_ff;
   event_type  s1_ev_ff, req_ev;
   logic [QADDR_W-1:0] s1_q;

   // Store ports
   logic [HEAD_W-1:0]          rd_head, eff_head, q_whead, p_wslot;
   logic [CNT_W-1:0]           rd_count, eff_count, q_wcount;
   pend_type [QUEUE_DEPTH-1:0] rd_row, eff_row;
   logic                       q_we, p_we;
   pend_type                   p_wdata;

   // Forwarding of the write made as the following transaction was read
   logic                byp_ff, wr_qwe_ff, wr_pwe_ff;
   logic [QADDR_W-1:0]  wr_q_ff;
   logic [HEAD_W-1:0]   wr_head_ff, wr_slot_ff;
   logic [CNT_W-1:0]    wr_cnt_ff;
   pend_type            wr_pdata_ff;

   // Per channel state
   logic [KEY_W-1:0]  program_ff    [CHANNELS];
   logic              pedal_down_ff [CHANNELS];
   logic [TICK_W-1:0] pedal_start_ff[CHANNELS];

   // Decode and record build
   logic              is_on, is_off, is_ctl, full, match, sustain, press, release_pd;
   logic              pd_cur;
   logic [TICK_W-1:0] ps_cur;
   logic [SUM_W-1:0]  slot_sum;
   pend_type          oldest;
   rec_type           base_rec, rec0, rec1;
   logic [1:0]        rec_n;

   // Output register
   rec_type    ob_rec_ff [2];
   logic [1:0] ob_cnt_ff;

   assign req_ev = '{action:     req_tuser,
                     tick:       req_tdata[30:0],
                     channel:    req_tdata[34:31],
                     number:     req_tdata[41:35],
                     level:      req_tdata[48:42],
                     bend:       req_tdata[62:49]};

   assign rsp_fire   = rsp_tvalid & rsp_tready;
   assign load_ok    = (ob_cnt_ff == 2'd0) || ((ob_cnt_ff == 2'd1) && rsp_fire);
   assign s1_go      = s1_valid_ff & load_ok;
   assign req_tready = clear_done & (~s1_valid_ff | s1_go);
   assign req_fire   = req_tvalid & req_tready;
   assign s1_q       = {s1_ev_ff.channel, s1_ev_ff.number};

   mnpe_note_store #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_store (
      .clock      (clock),
      .reset      (reset),
      .clear_done (clear_done),
      .rd_en      (req_fire),
      .rd_addr    ({req_ev.channel, req_ev.number}),
      .rd_head    (rd_head),
      .rd_count   (rd_count),
      .rd_row     (rd_row),
      .wr_addr    (s1_q),
      .q_we       (q_we),
      .q_whead    (q_whead),
      .q_wcount   (q_wcount),
      .p_we       (p_we),
      .p_wslot    (p_wslot),
      .p_wdata    (p_wdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         byp_ff      <= 1'b0;
      end else begin
         if (req_fire) begin
            s1_valid_ff <= 1'b1;
            byp_ff      <= s1_go;
         end else if (s1_go) begin
            s1_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_ev_ff <= req_ev;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_qwe_ff <= 1'b0;
         wr_pwe_ff <= 1'b0;
      end else if (s1_go) begin
         wr_qwe_ff <= q_we;
         wr_pwe_ff <= p_we;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_go) begin
         wr_q_ff     <= s1_q;
         wr_head_ff  <= q_whead;
         wr_cnt_ff   <= q_wcount;
         wr_slot_ff  <= p_wslot;
         wr_pdata_ff <= p_wdata;
      end
   end

   // Merge the write that the memory read missed.
   always_comb begin
      eff_head  = rd_head;
      eff_count = rd_count;
      eff_row   = rd_row;
      if (byp_ff && wr_qwe_ff && (wr_q_ff == s1_q)) begin
         eff_head  = wr_head_ff;
         eff_count = wr_cnt_ff;
         if (wr_pwe_ff) begin
            eff_row[wr_slot_ff] = wr_pdata_ff;
         end
      end
   end

   always_comb begin
      is_on      = (s1_ev_ff.action == ACT_NOTE_ON) && (s1_ev_ff.level != '0);
      is_off     = ((s1_ev_ff.action == ACT_NOTE_ON) || (s1_ev_ff.action == ACT_NOTE_OFF))
                   && !is_on;
      is_ctl     = (s1_ev_ff.action == ACT_CONTROL);
      full       = (eff_count >= DEPTH_C);
      oldest     = eff_row[eff_head];
      match      = is_off && (eff_count != '0) && (s1_ev_ff.tick > oldest.tick);
      slot_sum   = SUM_W'(eff_head) + SUM_W'(eff_count);
      pd_cur     = pedal_down_ff[s1_ev_ff.channel];
      ps_cur     = pedal_start_ff[s1_ev_ff.channel];
      sustain    = is_ctl && (s1_ev_ff.number == SUSTAIN_CTRL);
      press      = sustain && (s1_ev_ff.level >= PEDAL_ON_LEVEL);
      release_pd = sustain && (s1_ev_ff.level < PEDAL_ON_LEVEL) && pd_cur;
   end

   // Queue and pending memory updates
   always_comb begin
      q_we     = 1'b0;
      q_whead  = eff_head;
      q_wcount = eff_count;
      p_we     = 1'b0;
      p_wslot  = (slot_sum >= DEPTH_S) ? HEAD_W'(slot_sum - DEPTH_S) : HEAD_W'(slot_sum);
      p_wdata  = '{tick: s1_ev_ff.tick, vel: s1_ev_ff.level};
      if (is_on && !full) begin
         q_we     = s1_go;
         p_we     = s1_go;
         q_wcount = eff_count + 1'b1;
      end else if (match) begin
         q_we     = s1_go;
         q_whead  = (eff_head == HEAD_LAST_C) ? '0 : eff_head + 1'b1;
         q_wcount = eff_count - 1'b1;
      end
   end

   always_comb begin
      base_rec = '{kind:       KIND_NOTE,
                   channel:    s1_ev_ff.channel,
                   prog:       program_ff[s1_ev_ff.channel],
                   is_drum:    (s1_ev_ff.channel == DRUM_CHANNEL),
                   start_tick: s1_ev_ff.tick,
                   duration:   '0,
                   number:     s1_ev_ff.number,
                   level:      s1_ev_ff.level,
                   bend:       '0,
                   last:       1'b1};
      rec0  = base_rec;
      rec1  = base_rec;
      rec_n = 2'd0;
      if (is_on && full) begin
         rec0.kind = KIND_DROP;
         rec_n     = 2'd1;
      end else if (match) begin
         rec0.start_tick = oldest.tick;
         rec0.duration   = s1_ev_ff.tick - oldest.tick;
         rec0.level      = oldest.vel;
         rec_n           = 2'd1;
      end else if (is_ctl) begin
         rec0.kind = KIND_CONTROL;
         rec_n     = 2'd1;
         if (release_pd) begin
            rec0.last       = 1'b0;
            rec1.kind       = KIND_PEDAL;
            rec1.start_tick = ps_cur;
            rec1.duration   = s1_ev_ff.tick - ps_cur;
            rec1.number     = SUSTAIN_CTRL;
            rec1.level      = '0;
            rec_n           = 2'd2;
         end
      end else if (s1_ev_ff.action == ACT_BEND) begin
         rec0.kind   = KIND_BEND;
         rec0.number = '0;
         rec0.level  = '0;
         rec0.bend   = s1_ev_ff.bend;
         rec_n       = 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < CHANNELS; i++) begin
            program_ff[i]    <= '0;
            pedal_down_ff[i] <= 1'b0;
         end
      end else if (s1_go) begin
         if (s1_ev_ff.action == ACT_PROGRAM) begin
            program_ff[s1_ev_ff.channel] <= s1_ev_ff.number;
         end
         if (press && !pd_cur) begin
            pedal_down_ff[s1_ev_ff.channel] <= 1'b1;
         end else if (release_pd) begin
            pedal_down_ff[s1_ev_ff.channel] <= 1'b0;
         end
      end
   end

   // Keep the first start tick while the pedal stays down.
   always_ff @(posedge clock) begin
      if (s1_go && press && !pd_cur) begin
         pedal_start_ff[s1_ev_ff.channel] <= s1_ev_ff.tick;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ob_cnt_ff <= 2'd0;
      end else if (s1_go) begin
         ob_cnt_ff <= rec_n;
      end else if (rsp_fire) begin
         ob_cnt_ff <= ob_cnt_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_go) begin
         ob_rec_ff[0] <= rec0;
         ob_rec_ff[1] <= rec1;
      end else if (rsp_fire) begin
         ob_rec_ff[0] <= ob_rec_ff[1];
      end
   end

   assign rsp_tvalid = (ob_cnt_ff != 2'd0);
   assign rsp_tuser  = ob_rec_ff[0].kind;
   assign rsp_tlast  = ob_rec_ff[0].last;
   assign rsp_tdata  = {2'b00,
                        ob_rec_ff[0].bend,
                        ob_rec_ff[0].level,
                        ob_rec_ff[0].number,
                        ob_rec_ff[0].duration,
                        ob_rec_ff[0].start_tick,
                        ob_rec_ff[0].is_drum,
                        ob_rec_ff[0].prog,
                        ob_rec_ff[0].channel};

endmodule

// ===== src/mnpe_note_store.sv =====
// Queue state and pending note-on memories with the post-reset clearing sweep.
module mnpe_note_store #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic                                   clock,
   input  logic                                   reset,
   output logic                                   clear_done,
   input  logic                                   rd_en,
   input  logic [mnpe_pkg::QADDR_W-1:0]           rd_addr,
   output logic [((QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1)-1:0] rd_head,
   output logic [$clog2(QUEUE_DEPTH+1)-1:0]       rd_count,
   output mnpe_pkg::pend_type [QUEUE_DEPTH-1:0]   rd_row,
   input  logic [mnpe_pkg::QADDR_W-1:0]           wr_addr,
   input  logic                                   q_we,
   input  logic [((QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1)-1:0] q_whead,
   input  logic [$clog2(QUEUE_DEPTH+1)-1:0]       q_wcount,
   input  logic                                   p_we,
   input  logic [((QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1)-1:0] p_wslot,
   input  mnpe_pkg::pend_type                     p_wdata
);
   import mnpe_pkg::*;

   localparam int HEAD_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
   localparam int QS_W   = HEAD_W + CNT_W;

   logic [QS_W-1:0]                 qmem [QROWS];
   pend_type [QUEUE_DEPTH-1:0]      pmem [QROWS];
   logic [QS_W-1:0]                 rd_qs_ff;
   pend_type [QUEUE_DEPTH-1:0]      rd_row_ff;
   logic [QADDR_W:0]                clr_ff;

   assign clear_done = clr_ff[QADDR_W];

   // Sweep the queue state to zero once after reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
      end else if (!clear_done) begin
         clr_ff <= clr_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (!clear_done) begin
         qmem[clr_ff[QADDR_W-1:0]] <= '0;
      end else if (q_we) begin
         qmem[wr_addr] <= {q_whead, q_wcount};
      end
      if (rd_en) begin
         rd_qs_ff <= qmem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (p_we) begin
         pmem[wr_addr][p_wslot] <= p_wdata;
      end
      if (rd_en) begin
         rd_row_ff <= pmem[rd_addr];
      end
   end

   assign rd_head  = rd_qs_ff[QS_W-1:CNT_W];
   assign rd_count = rd_qs_ff[CNT_W-1:0];
   assign rd_row   = rd_row_ff;

endmodule

// ===== src/mnpe_checker.sv =====
// Port-level checks for the MIDI note pairing engine, bound to the top level.
module mnpe_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_tready,
   input logic                              rsp_tvalid,
   input logic                              rsp_tready,
   input logic [mnpe_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   input logic [mnpe_pkg::CODE_W-1:0]       rsp_tuser,
   input logic                              rsp_tlast
);
   import mnpe_pkg::*;

   // Reset empties the output and starts the clearing sweep.
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_tvalid && !req_tready)
      else $error("transaction possible straight after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=>
         rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("stalled result changed");

   // A paired note always lasts at least one tick.
   a_note_length: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == KIND_NOTE) |-> (rsp_tdata[73:43] != '0))
      else $error("note record with zero duration");

   // A pedal record only follows its control record, so it is last and names the sustain controller.
   a_pedal_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == KIND_PEDAL) |->
         rsp_tlast && (rsp_tdata[80:74] == SUSTAIN_CTRL))
      else $error("pedal record malformed");

   a_bend_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == KIND_BEND) |->
         rsp_tlast && (rsp_tdata[87:74] == '0) && (rsp_tdata[73:43] == '0))
      else $error("pitch bend record carries note fields");

endmodule

bind midi_note_pairing_engine mnpe_checker u_mnpe_checker (.*);

// ===== test/testbench.sv =====
// Testbench for the note pairing engine: a directed table, then random event streams.
`timescale 1ns / 1ps

module testbench;
   import mnpe_pkg::*;

   localparam int QUEUE_DEPTH = 4;
   localparam int EVENT_COUNT = 1550;
   localparam int IDLE_PCT    = 12;

   typedef struct packed {
      event_type ev;
      bit        typed;
      rec_type   rec;
   } step_row_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic [CODE_W-1:0]     req_tuser = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [CODE_W-1:0]     rsp_tuser;
   logic                  rsp_tlast;

   // predictor state
   logic [TICK_W-1:0]  held_tick [QROWS][QUEUE_DEPTH];
   logic [LEVEL_W-1:0] held_vel  [QROWS][QUEUE_DEPTH];
   int unsigned        slot_head [QROWS];
   int unsigned        slot_fill [QROWS];
   logic [KEY_W-1:0]   chan_prog [CHANNELS];
   bit                 sustain_on   [CHANNELS];
   logic [TICK_W-1:0]  sustain_from [CHANNELS];

   rec_type      fresh_records[$];
   rec_type      due_records[$];
   step_row_type script[$];
   bit           calm = 1'b0;
   int           faults = 0;
   logic [TICK_W-1:0] now_tick = '0;

   midi_note_pairing_engine #(.QUEUE_DEPTH(QUEUE_DEPTH)) DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   initial begin
      #1_000_000;
      $display("*** FAILED ***");
      $finish;
   end

   function automatic event_type ev_of(logic [CODE_W-1:0] act, logic [TICK_W-1:0] tk,
                                       logic [CHAN_W-1:0] ch, logic [KEY_W-1:0] nm,
                                       logic [LEVEL_W-1:0] lv, logic signed [BEND_W-1:0] bd);
      event_type ev;
      ev.action  = act;
      ev.tick    = tk;
      ev.channel = ch;
      ev.number  = nm;
      ev.level   = lv;
      ev.bend    = bd;
      return ev;
   endfunction

   function automatic rec_type rec_of(logic [CODE_W-1:0] kd, logic [CHAN_W-1:0] ch,
                                      logic [KEY_W-1:0] prog, logic [TICK_W-1:0] st,
                                      logic [TICK_W-1:0] dur, logic [KEY_W-1:0] nm,
                                      logic [LEVEL_W-1:0] lv, logic signed [BEND_W-1:0] bd);
      rec_type r;
      r.kind       = kd;
      r.channel    = ch;
      r.prog       = prog;
      r.is_drum    = (ch == DRUM_CHANNEL);
      r.start_tick = st;
      r.duration   = dur;
      r.number     = nm;
      r.level      = lv;
      r.bend       = bd;
      r.last       = 1'b1;
      return r;
   endfunction

   task automatic plain(input event_type ev);
      step_row_type s;
      s.ev    = ev;
      s.typed = 1'b0;
      s.rec   = '0;
      script.insert(script.size(), s);
   endtask

   task automatic typed(input event_type ev, input rec_type r);
      step_row_type s;
      s.ev    = ev;
      s.typed = 1'b1;
      s.rec   = r;
      script.insert(script.size(), s);
   endtask

   // Work out the records that one accepted event yields, and advance the state.
   task automatic pair_event(input event_type ev);
      int unsigned   row;
      int unsigned   slot;
      logic [TICK_W-1:0] st;
      logic [CHAN_W-1:0] ch;
      ch  = ev.channel;
      row = 32'({ev.channel, ev.number});
      fresh_records.delete();
      if (ev.action == ACT_NOTE_ON && ev.level != 0) begin
         if (slot_fill[row] >= QUEUE_DEPTH) begin
            fresh_records.insert(fresh_records.size(),
                                 rec_of(KIND_DROP, ch, chan_prog[ch], ev.tick, '0,
                                        ev.number, ev.level, '0));
         end else begin
            slot = (slot_head[row] + slot_fill[row]) % QUEUE_DEPTH;
            held_tick[row][slot] = ev.tick;
            held_vel[row][slot]  = ev.level;
            slot_fill[row]++;
         end
      end else if (ev.action == ACT_NOTE_ON || ev.action == ACT_NOTE_OFF) begin
         // pair only with the oldest pending note-on, and only if strictly later
         if (slot_fill[row] != 0) begin
            st = held_tick[row][slot_head[row]];
            if (ev.tick > st) begin
               fresh_records.insert(fresh_records.size(),
                                    rec_of(KIND_NOTE, ch, chan_prog[ch], st, ev.tick - st,
                                           ev.number, held_vel[row][slot_head[row]], '0));
               slot_head[row] = (slot_head[row] + 1) % QUEUE_DEPTH;
               slot_fill[row]--;
            end
         end
      end else if (ev.action == ACT_PROGRAM) begin
         chan_prog[ch] = ev.number;
      end else if (ev.action == ACT_CONTROL) begin
         fresh_records.insert(fresh_records.size(),
                              rec_of(KIND_CONTROL, ch, chan_prog[ch], ev.tick, '0,
                                     ev.number, ev.level, '0));
         if (ev.number == SUSTAIN_CTRL) begin
            if (ev.level >= PEDAL_ON_LEVEL) begin
               if (!sustain_on[ch]) begin
                  sustain_on[ch]   = 1'b1;
                  sustain_from[ch] = ev.tick;
               end
            end else if (sustain_on[ch]) begin
               st = sustain_from[ch];
               fresh_records.insert(fresh_records.size(),
                                    rec_of(KIND_PEDAL, ch, chan_prog[ch], st, ev.tick - st,
                                           SUSTAIN_CTRL, '0, '0));
               sustain_on[ch] = 1'b0;
            end
         end
      end else if (ev.action == ACT_BEND) begin
         fresh_records.insert(fresh_records.size(),
                              rec_of(KIND_BEND, ch, chan_prog[ch], ev.tick, '0, '0, '0,
                                     ev.bend));
      end
      foreach (fresh_records[i]) fresh_records[i].last = (i == fresh_records.size() - 1);
   endtask

   task automatic send_event(input step_row_type s, input bit hold);
      if (hold) begin
         // drain the engine before going on
         req_tvalid <= 1'b0;
         @(posedge clock);
         while (due_records.size() != 0) @(posedge clock);
      end
      if (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {1'b0, s.ev.bend, s.ev.level, s.ev.number, s.ev.channel, s.ev.tick};
      req_tuser  <= s.ev.action;
      do @(posedge clock); while (!req_tready);
      pair_event(s.ev);
      if (s.typed) due_records.insert(due_records.size(), s.rec);
      else foreach (fresh_records[i]) due_records.insert(due_records.size(), fresh_records[i]);
   endtask

   // Busy channels and pitches keep the queues filling and pairing.
   task automatic random_event(output event_type ev, output bit counted);
      int          r;
      logic [CHAN_W-1:0] ch;
      logic [KEY_W-1:0]  nm;
      logic [TICK_W-1:0] tk;
      counted = 1'b1;
      if ($urandom_range(0, 3) != 0) begin
         case ($urandom_range(0, 3))
            0:       ch = 4'd0;
            1:       ch = 4'd1;
            2:       ch = DRUM_CHANNEL;
            default: ch = 4'd15;
         endcase
         nm = 7'd60 + 7'($urandom_range(0, 2));
      end else begin
         ch = 4'($urandom);
         nm = 7'($urandom);
      end
      if ($urandom_range(0, 99) == 0) now_tick = 31'($urandom);
      now_tick = now_tick + 31'($urandom_range(0, 40));
      tk = ($urandom_range(0, 99) < 5) ? 31'($urandom) : now_tick;
      r = $urandom_range(0, 99);
      if (r < 36)
         ev = ev_of(ACT_NOTE_ON, tk, ch, nm, 7'($urandom_range(1, 127)), 14'($urandom));
      else if (r < 40)
         ev = ev_of(ACT_NOTE_ON, tk, ch, nm, '0, 14'($urandom));
      else if (r < 68)
         ev = ev_of(ACT_NOTE_OFF, tk, ch, nm, 7'($urandom), 14'($urandom));
      else if (r < 80)
         ev = ev_of(ACT_CONTROL, tk, ch, $urandom_range(0, 1) ? SUSTAIN_CTRL : 7'($urandom),
                    7'($urandom), 14'($urandom));
      else if (r < 85)
         ev = ev_of(ACT_PROGRAM, tk, ch, 7'($urandom), 7'($urandom), 14'($urandom));
      else if (r < 97)
         ev = ev_of(ACT_BEND, tk, ch, 7'($urandom), 7'($urandom), 14'($urandom));
      else begin
         ev = ev_of(ACT_BEND + 3'($urandom_range(1, 3)), tk, ch, nm, 7'($urandom),
                    14'($urandom));
         counted = 1'b0;
      end
   endtask

   task automatic check_field(input string name, input longint want, input longint got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         faults++;
      end
   endtask

   always @(posedge clock) begin
      rsp_tready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
   end

   always @(posedge clock) begin
      rec_type got;
      rec_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.kind       = rsp_tuser;
         got.channel    = rsp_tdata[3:0];
         got.prog       = rsp_tdata[10:4];
         got.is_drum    = rsp_tdata[11];
         got.start_tick = rsp_tdata[42:12];
         got.duration   = rsp_tdata[73:43];
         got.number     = rsp_tdata[80:74];
         got.level      = rsp_tdata[87:81];
         got.bend       = rsp_tdata[101:88];
         got.last       = rsp_tlast;
         if (due_records.size() == 0) begin
            $error("record with none awaited: kind %0d channel %0d", got.kind, got.channel);
            faults++;
         end else begin
            want = due_records.pop_front();
            check_field("kind", want.kind, got.kind);
            check_field("channel", want.channel, got.channel);
            check_field("program", want.prog, got.prog);
            check_field("is_drum", want.is_drum, got.is_drum);
            check_field("start_tick", want.start_tick, got.start_tick);
            check_field("duration", want.duration, got.duration);
            check_field("number", want.number, got.number);
            check_field("level", want.level, got.level);
            check_field("bend", want.bend, got.bend);
            check_field("last", want.last, got.last);
         end
      end
   end

   initial begin
      event_type    ev;
      bit           counted;
      step_row_type s;
      int           done;

      foreach (slot_head[i]) begin
         slot_head[i] = 0;
         slot_fill[i] = 0;
      end
      foreach (chan_prog[i]) begin
         chan_prog[i]    = '0;
         sustain_on[i]   = 1'b0;
         sustain_from[i] = '0;
      end

      // directed part
      typed(ev_of(ACT_BEND, 31'd0, 4'd0, 7'd0, 7'd0, -14'sd8192),
            rec_of(KIND_BEND, 4'd0, 7'd0, 31'd0, 31'd0, 7'd0, 7'd0, -14'sd8192));
      typed(ev_of(ACT_BEND, 31'h7FFF_FFFF, DRUM_CHANNEL, 7'd127, 7'd127, 14'sd8191),
            rec_of(KIND_BEND, DRUM_CHANNEL, 7'd0, 31'h7FFF_FFFF, 31'd0, 7'd0, 7'd0,
                   14'sd8191));
      typed(ev_of(ACT_CONTROL, 31'd5, 4'd15, 7'd7, 7'd100, 14'sd0),
            rec_of(KIND_CONTROL, 4'd15, 7'd0, 31'd5, 31'd0, 7'd7, 7'd100, 14'sd0));
      // pedal release while up: control record only
      typed(ev_of(ACT_CONTROL, 31'd10, 4'd3, SUSTAIN_CTRL, 7'd0, 14'sd0),
            rec_of(KIND_CONTROL, 4'd3, 7'd0, 31'd10, 31'd0, SUSTAIN_CTRL, 7'd0, 14'sd0));
      plain(ev_of(ACT_PROGRAM, 31'd20, 4'd2, 7'd127, 7'd0, 14'sd0));
      plain(ev_of(ACT_NOTE_ON, 31'd100, 4'd2, 7'd60, 7'd127, 14'sd0));
      plain(ev_of(ACT_NOTE_ON, 31'd100, 4'd2, 7'd60, 7'd1, 14'sd0));
      plain(ev_of(ACT_NOTE_ON, 31'd110, 4'd2, 7'd60, 7'd50, 14'sd0));
      plain(ev_of(ACT_NOTE_ON, 31'd120, 4'd2, 7'd60, 7'd64, 14'sd0));
      // queue full: dropped
      typed(ev_of(ACT_NOTE_ON, 31'd130, 4'd2, 7'd60, 7'd90, 14'sd0),
            rec_of(KIND_DROP, 4'd2, 7'd127, 31'd130, 31'd0, 7'd60, 7'd90, 14'sd0));
      // note-off not later than the oldest start: nothing
      plain(ev_of(ACT_NOTE_OFF, 31'd100, 4'd2, 7'd60, 7'd0, 14'sd0));
      plain(ev_of(ACT_NOTE_OFF, 31'd150, 4'd2, 7'd60, 7'd33, 14'sd0));
      plain(ev_of(ACT_NOTE_ON, 31'd160, 4'd2, 7'd60, 7'd0, 14'sd0));
      plain(ev_of(ACT_NOTE_OFF, 31'd5, 4'd5, 7'd0, 7'd0, 14'sd0));
      plain(ev_of(ACT_CONTROL, 31'd1000, 4'd4, SUSTAIN_CTRL, 7'd127, 14'sd0));
      plain(ev_of(ACT_CONTROL, 31'd1100, 4'd4, SUSTAIN_CTRL, PEDAL_ON_LEVEL, 14'sd0));
      // release ahead of the start tick wraps the duration
      plain(ev_of(ACT_CONTROL, 31'd500, 4'd4, SUSTAIN_CTRL, 7'd63, 14'sd0));
      plain(ev_of(ACT_BEND + 3'd1, 31'd600, 4'd1, 7'd1, 7'd1, 14'sd1));
      plain(ev_of(ACT_BEND + 3'd2, 31'd600, 4'd1, 7'd1, 7'd1, 14'sd1));
      plain(ev_of(ACT_BEND + 3'd3, 31'd600, 4'd1, 7'd1, 7'd1, 14'sd1));
      plain(ev_of(ACT_NOTE_ON, 31'h7FFF_FFFE, DRUM_CHANNEL, 7'd127, 7'd127, 14'sd0));
      plain(ev_of(ACT_NOTE_OFF, 31'h7FFF_FFFF, DRUM_CHANNEL, 7'd127, 7'd127, 14'sd0));
      plain(ev_of(ACT_NOTE_ON, 31'd0, 4'd0, 7'd0, 7'd1, 14'sd0));
      plain(ev_of(ACT_NOTE_OFF, 31'h7FFF_FFFF, 4'd0, 7'd0, 7'd0, 14'sd0));

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (script[i]) send_event(script[i], 1'b0);

      done = 0;
      while (done < EVENT_COUNT - script.size()) begin
         random_event(ev, counted);
         calm = (done >= 500 && done < 800);
         s.ev    = ev;
         s.typed = 1'b0;
         s.rec   = '0;
         send_event(s, counted && done == 1000);
         if (counted) done++;
      end
      req_tvalid <= 1'b0;
      calm = 1'b0;

      while (due_records.size() != 0) @(posedge clock);
      repeat (16) @(posedge clock);
      if (faults == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
